@@ rtl/lzss_pkg.sv @@
`default_nettype none
package lzss_pkg;

	localparam int DIST_W         = 12;
	localparam int LEN_W          = 4;
	localparam int CNT_W          = 32;
	localparam int CMD_FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_TOKEN,
		PH_REF2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_DIST  = 2'd2,
		ST_CAP   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_STAT
	} cmd_kind_t;

	// One classified token on its way from the parser to the output engine.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         lit;
		logic [DIST_W-1:0]  dist_m1;
		logic [LEN_W-1:0]   len_m3;
		logic               last;
		status_t            status;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             has_data;
		logic             run_last;
		logic             done;
		status_t          status;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/lzss_if.sv @@
`default_nettype none
interface lzss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        has_data;
	logic        run_last;
	logic        stream_done;
	logic [1:0]  status;
	logic [31:0] total_count;

	modport source (output valid, output out_byte, output has_data, output run_last,
		output stream_done, output status, output total_count, input ready);
	modport sink   (input valid, input out_byte, input has_data, input run_last,
		input stream_done, input status, input total_count, output ready);
endinterface
`default_nettype wire

@@ rtl/lzss_stream_decompressor_top.sv @@
`default_nettype none
// LZSS stream decompressor. Compressed bytes arrive one per transaction on cmp_stream, with
// in_last marking the final byte of a stream; decompressed bytes and stream status leave on
// raw_stream, one result per transaction. A parser accepts one input byte per clock cycle and
// turns each literal, back reference or stream end into a command held in a four-entry queue;
// the parser stalls only while that queue is full. An output engine drains the queue and
// produces one result per cycle while the queue is not empty and raw_stream is ready: a
// literal or a status command gives one result, a back reference of length 3 to 18 gives one
// result per copied byte, because every copied byte is one read of the history memory
// (HISTORY_DEPTH bytes, one read and one write port). A header byte or the first byte of a
// back reference not marked in_last gives the engine no command. Commands pass the queue, a
// read stage and an output register. The user writes output_capacity through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. It resets to all ones. After
// an error the block reports one status result with a count of zero and then drops input up
// to and including the next byte marked in_last. No clearing pass is needed after reset: the
// history is only read where the current stream has already written it.
module lzss_stream_decompressor_top #(
	parameter int HISTORY_DEPTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	lzss_in_if.sink          cmp_stream,
	lzss_out_if.source       raw_stream
);
	import lzss_pkg::*;

	logic [31:0] cap_q;
	cmd_t        push_cmd;
	cmd_t        head_cmd;
	logic        push;
	logic        full;
	logic        pop;
	logic        empty;

	// Capacity register: one full word, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Parser: tracks flag bits and the byte count, checks distance and capacity up front.
	lzss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.cmp      (cmp_stream),
		.cmd      (push_cmd),
		.cmd_push (push),
		.cmd_full (full)
	);

	// Command queue that lets the parser run ahead of the output engine.
	lzss_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (full),
		.pop    (pop),
		.dout   (head_cmd),
		.empty  (empty)
	);

	// Output engine: history memory, copy sequencing and the output register.
	lzss_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_cmd),
		.empty  (empty),
		.pop    (pop),
		.raw    (raw_stream)
	);

endmodule
`default_nettype wire

@@ rtl/lzss_front.sv @@
`default_nettype none
module lzss_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   capacity,
	lzss_in_if.sink            cmp,
	output lzss_pkg::cmd_t     cmd,
	output logic               cmd_push,
	input  wire logic          cmd_full
);
	import lzss_pkg::*;

	phase_t           phase_q, phase_d;
	logic [7:0]       flag_q, flag_d;
	logic [2:0]       idx_q, idx_d;
	logic [7:0]       hold_q, hold_d;
	logic             discard_q, discard_d;
	logic [CNT_W-1:0] pc_q, pc_d;

	logic             take;
	logic [7:0]       b;
	logic             last;
	logic [12:0]      ref_dist;
	logic [4:0]       len;
	status_t          err;

	assign cmp.ready = !cmd_full;
	assign take      = cmp.valid && cmp.ready;
	assign b         = cmp.in_byte;
	assign last      = cmp.in_last;
	assign ref_dist  = {1'b0, b[3:0], hold_q} + 13'd1;
	assign len       = {1'b0, b[7:4]} + 5'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAG;
			flag_q    <= '0;
			idx_q     <= '0;
			hold_q    <= '0;
			discard_q <= 1'b0;
			pc_q      <= '0;
		end else begin
			phase_q   <= phase_d;
			flag_q    <= flag_d;
			idx_q     <= idx_d;
			hold_q    <= hold_d;
			discard_q <= discard_d;
			pc_q      <= pc_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		flag_d      = flag_q;
		idx_d       = idx_q;
		hold_d      = hold_q;
		discard_d   = discard_q;
		pc_d        = pc_q;
		err         = ST_OK;
		cmd_push    = 1'b0;
		cmd.kind    = CMD_STAT;
		cmd.lit     = b;
		cmd.dist_m1 = {b[3:0], hold_q};
		cmd.len_m3  = b[7:4];
		cmd.last    = last;
		cmd.status  = ST_OK;

		if (take) begin
			if (discard_q) begin
				if (last) begin
					discard_d = 1'b0;
					phase_d   = PH_FLAG;
					flag_d    = '0;
					idx_d     = '0;
					hold_d    = '0;
					pc_d      = '0;
				end
			end else begin
				unique case (phase_q)
					PH_FLAG: begin
						flag_d  = b;
						idx_d   = '0;
						phase_d = PH_TOKEN;
						if (last) begin
							cmd_push = 1'b1;
							cmd.kind = CMD_STAT;
						end
					end
					PH_TOKEN: begin
						if (flag_q[idx_q]) begin
							if (pc_q >= capacity) begin
								err = ST_CAP;
							end else begin
								cmd_push = 1'b1;
								cmd.kind = CMD_LIT;
								pc_d     = pc_q + 32'd1;
								idx_d    = idx_q + 3'd1;
								phase_d  = (idx_q == 3'd7) ? PH_FLAG : PH_TOKEN;
							end
						end else if (last) begin
							err = ST_TRUNC;
						end else begin
							hold_d  = b;
							phase_d = PH_REF2;
						end
					end
					PH_REF2: begin
						if (32'(ref_dist) > pc_q) begin
							err = ST_DIST;
						end else if (({1'b0, pc_q} + 33'(len)) > {1'b0, capacity}) begin
							err = ST_CAP;
						end else begin
							cmd_push = 1'b1;
							cmd.kind = CMD_COPY;
							pc_d     = pc_q + 32'(len);
							idx_d    = idx_q + 3'd1;
							phase_d  = (idx_q == 3'd7) ? PH_FLAG : PH_TOKEN;
						end
					end
					default: begin
						phase_d = PH_FLAG;
					end
				endcase

				if (err != ST_OK) begin
					cmd_push   = 1'b1;
					cmd.kind   = CMD_STAT;
					cmd.status = err;
					discard_d  = !last;
				end

				if (last) begin
					discard_d = 1'b0;
					phase_d   = PH_FLAG;
					flag_d    = '0;
					idx_d     = '0;
					hold_d    = '0;
					pc_d      = '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lzss_cmd_fifo.sv @@
`default_nettype none
module lzss_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lzss_pkg::cmd_t din,
	output logic                full,
	input  wire logic           pop,
	output lzss_pkg::cmd_t      dout,
	output logic                empty
);
	import lzss_pkg::*;

	localparam int PW = $clog2(CMD_FIFO_DEPTH);

	cmd_t        entry_q [CMD_FIFO_DEPTH];
	logic [PW:0] wr_q;
	logic [PW:0] rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[PW-1:0] == rd_q[PW-1:0]) && (wr_q[PW] != rd_q[PW]);
	assign dout  = entry_q[rd_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_q[PW-1:0]] <= din;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lzss_back.sv @@
`default_nettype none
module lzss_back #(
	parameter int HISTORY_DEPTH = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lzss_pkg::cmd_t head,
	input  wire logic           empty,
	output logic                pop,
	lzss_out_if.source          raw
);
	import lzss_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic [7:0]       hist [HISTORY_DEPTH];

	logic [CNT_W-1:0] iss_q;
	logic [4:0]       k_q;

	logic             b_valid_s1;
	res_t             b_res_s1;
	logic             b_mem_s1;
	logic             b_fwd_s1;
	logic [7:0]       fwd_byte_s1;
	logic [7:0]       rd_data_s1;

	logic             o_valid_s2;
	res_t             o_res_s2;

	logic [7:0]       b_byte;
	res_t             b_out;
	logic [AW-1:0]    b_addr;
	logic [AW-1:0]    rd_addr;
	logic             b_adv;
	logic             issue;
	logic             fwd;
	logic             fin;
	res_t             nres;
	logic             nvalid;
	logic             is_mem;
	logic             last_issue;
	logic             stream_end;

	assign b_byte  = b_fwd_s1 ? fwd_byte_s1 : (b_mem_s1 ? rd_data_s1 : b_res_s1.data);
	assign b_addr  = b_res_s1.count[AW-1:0] - AW'(1);
	assign rd_addr = iss_q[AW-1:0] - AW'(head.dist_m1) - AW'(1);
	assign b_adv   = b_valid_s1 && (!o_valid_s2 || raw.ready);
	assign issue   = !empty && (!b_valid_s1 || b_adv);
	// The byte just ahead in the pipeline is written on the same edge as this read.
	assign fwd     = b_valid_s1 && b_res_s1.has_data && (rd_addr == b_addr);
	assign fin     = (k_q == ({1'b0, head.len_m3} + 5'd2));
	assign pop     = issue && last_issue;

	always_comb begin
		b_out      = b_res_s1;
		b_out.data = b_byte;
	end

	always_comb begin
		nvalid        = 1'b1;
		is_mem        = 1'b0;
		last_issue    = 1'b1;
		stream_end    = 1'b0;
		nres.data     = '0;
		nres.has_data = 1'b0;
		nres.run_last = 1'b1;
		nres.done     = 1'b0;
		nres.status   = ST_OK;
		nres.count    = iss_q + 32'd1;
		unique case (head.kind)
			CMD_LIT: begin
				nres.data     = head.lit;
				nres.has_data = 1'b1;
				nres.done     = head.last;
				stream_end    = head.last;
			end
			CMD_COPY: begin
				is_mem        = 1'b1;
				nres.has_data = 1'b1;
				nres.run_last = fin;
				nres.done     = fin && head.last;
				last_issue    = fin;
				stream_end    = fin && head.last;
			end
			CMD_STAT: begin
				nres.done   = 1'b1;
				nres.status = head.status;
				nres.count  = (head.status == ST_OK) ? iss_q : '0;
				stream_end  = 1'b1;
			end
			default: begin
				nvalid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q      <= '0;
			k_q        <= '0;
			b_valid_s1 <= 1'b0;
			o_valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				b_valid_s1 <= nvalid;
				k_q        <= last_issue ? 5'd0 : k_q + 5'd1;
				if (stream_end) begin
					iss_q <= '0;
				end else if (nvalid && nres.has_data) begin
					iss_q <= iss_q + 32'd1;
				end
			end else if (b_adv) begin
				b_valid_s1 <= 1'b0;
			end
			if (b_adv) begin
				o_valid_s2 <= 1'b1;
			end else if (raw.ready) begin
				o_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			b_res_s1    <= nres;
			b_mem_s1    <= is_mem;
			b_fwd_s1    <= fwd && is_mem;
			fwd_byte_s1 <= b_byte;
		end
		if (b_adv) begin
			o_res_s2 <= b_out;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && is_mem) begin
			rd_data_s1 <= hist[rd_addr];
		end
		if (b_adv && b_res_s1.has_data) begin
			hist[b_addr] <= b_byte;
		end
	end

	assign raw.valid       = o_valid_s2;
	assign raw.out_byte    = o_res_s2.data;
	assign raw.has_data    = o_res_s2.has_data;
	assign raw.run_last    = o_res_s2.run_last;
	assign raw.stream_done = o_res_s2.done;
	assign raw.status      = o_res_s2.status;
	assign raw.total_count = o_res_s2.count;

endmodule
`default_nettype wire

@@ rtl/lzss_checker.sv @@
`default_nettype none
module lzss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [7:0]  out_byte,
	input wire logic        has_data,
	input wire logic        run_last,
	input wire logic        stream_done,
	input wire logic [1:0]  status,
	input wire logic [31:0] total_count
);
	import lzss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(total_count)
			&& $stable(has_data) && $stable(status))
		else $error("result changed while stalled");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !has_data |-> run_last && stream_done)
		else $error("status result without end marks");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status != ST_OK) |-> !has_data && (total_count == 32'd0))
		else $error("error result carries data or a count");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stream_done |-> run_last)
		else $error("stream end not on the last result of a transaction");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && has_data |-> (total_count != 32'd0) && (status == ST_OK))
		else $error("data byte with zero count or bad status");

endmodule

bind lzss_stream_decompressor_top lzss_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (raw_stream.valid),
	.ready       (raw_stream.ready),
	.out_byte    (raw_stream.out_byte),
	.has_data    (raw_stream.has_data),
	.run_last    (raw_stream.run_last),
	.stream_done (raw_stream.stream_done),
	.status      (raw_stream.status),
	.total_count (raw_stream.total_count)
);
`default_nettype wire
